>>> sv/sxfc_pkg.sv
// Shared types and constants of the streaming XPath fragment cutter.
package sxfc_pkg;

    localparam int RULES_DEF      = 16;
    localparam int PATH_DEPTH_DEF = 16;
    localparam int TAG_BITS_DEF   = 16;

    localparam int TAG_ID_W = 16;
    localparam int OFFSET_W = 48;
    localparam int DEPTH_W  = 16;

    typedef enum logic [1:0] {
        CMD_START      = 2'd0,
        CMD_END        = 2'd1,
        CMD_WRITE_STEP = 2'd2,
        CMD_WRITE_LEN  = 2'd3
    } cmd_t;

    typedef enum logic {
        REG_RULE_COUNT = 1'b0,
        REG_DOCUMENT   = 1'b1
    } reg_idx_t;

    typedef struct packed {
        cmd_t                  command;
        logic [TAG_ID_W-1:0]   tag_id;
        logic [OFFSET_W-1:0]   source_offset;
        logic [3:0]            rule_select;
        logic [3:0]            step_select;
        logic [4:0]            rule_length;
        logic                  header_flag;
    } evt_t;

    typedef struct packed {
        logic [31:0]           segment_number;
        logic [3:0]            segment_rule;
        logic [15:0]           segment_document;
        logic [OFFSET_W-1:0]   segment_start;
        logic [OFFSET_W-1:0]   segment_length;
        logic                  segment_header;
    } seg_t;

    // Rule table write request, one beat of a table command.
    typedef struct packed {
        logic                  step_we;
        logic                  len_we;
        logic [3:0]            rule;
        logic [3:0]            step;
        logic [TAG_ID_W-1:0]   tag;
        logic [4:0]            len;
        logic                  hdr;
    } rule_wr_t;

endpackage

>>> sv/sxfc_rule_store.sv
// Rule step memory, rule length and header tables, and per-rule step compare.
module sxfc_rule_store #(
    parameter int RULES      = sxfc_pkg::RULES_DEF,
    parameter int PATH_DEPTH = sxfc_pkg::PATH_DEPTH_DEF,
    parameter int TAG_BITS   = sxfc_pkg::TAG_BITS_DEF,
    localparam int TW = (TAG_BITS < sxfc_pkg::TAG_ID_W) ? TAG_BITS : sxfc_pkg::TAG_ID_W,
    localparam int DW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1,
    localparam int RW = (RULES > 1) ? $clog2(RULES) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sxfc_pkg::rule_wr_t            wr,
    input  logic                          rd_en,
    input  logic [DW-1:0]                 rd_row,
    input  logic [TW-1:0]                 cmp_tag,
    input  logic [sxfc_pkg::DEPTH_W-1:0]  cmp_depth,
    input  logic [3:0]                    hdr_rule,
    output logic [RULES-1:0]              cand,
    output logic [RULES-1:0]              done,
    output logic                          hdr_bit
);

    // One row per path step, one lane per rule.
    logic [RULES*TW-1:0] step_mem [PATH_DEPTH];
    logic [RULES*TW-1:0] row_q;
    logic [4:0]          len_reg [RULES];
    logic                hdr_reg [RULES];
    logic                step_ok;
    logic                rule_ok;

    assign rule_ok = int'(wr.rule) < RULES;
    assign step_ok = rule_ok && (int'(wr.step) < PATH_DEPTH);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RULES; i++)
        begin
            if (wr.step_we && step_ok && int'(wr.rule) == i)
            begin
                step_mem[DW'(wr.step)][i*TW +: TW] <= wr.tag[TW-1:0];
            end
        end
        if (rd_en)
        begin
            row_q <= step_mem[rd_row];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RULES; i++)
            begin
                len_reg[i] <= '0;
                hdr_reg[i] <= 1'b0;
            end
        end
        else
        begin
            for (int i = 0; i < RULES; i++)
            begin
                if (wr.len_we && rule_ok && int'(wr.rule) == i)
                begin
                    len_reg[i] <= wr.len;
                    hdr_reg[i] <= wr.hdr;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < RULES; i++)
        begin
            cand[i] = (row_q[i*TW +: TW] == cmp_tag)
                      && (cmp_depth <= {11'd0, len_reg[i]});
            done[i] = (cmp_depth == {11'd0, len_reg[i]});
        end
    end

    assign hdr_bit = (int'(hdr_rule) < RULES) ? hdr_reg[RW'(hdr_rule)] : 1'b0;

endmodule

>>> sv/streaming_xpath_fragment_cutter.sv
// Top level of the streaming XPath fragment cutter: event sequencer and level mask memory.
//
//  channel   dir  handshake        payload
//  evt       in   evt_valid/ready  sxfc_pkg::evt_t (command, tag, offset, table write fields)
//  seg       out  seg_valid/ready  sxfc_pkg::seg_t (one segment per closing end event)
//  apb       in   psel/penable     rule_count at 0x0, document_number at 0x4
//
// Every event passes through S_IDLE and S_EXEC: for a start event the accept cycle issues
// the reads of the step row and the parent level mask, and S_EXEC compares all rules and
// writes the new level mask. An end event that closes a capture waits in S_EXEC while the
// segment register is still full. Reset clears depth, capture state, segment counter, rule
// lengths and headers; the step and mask memories are not cleared.
module streaming_xpath_fragment_cutter #(
    parameter int RULES      = sxfc_pkg::RULES_DEF,
    parameter int PATH_DEPTH = sxfc_pkg::PATH_DEPTH_DEF,
    parameter int TAG_BITS   = sxfc_pkg::TAG_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           evt_valid,
    output logic           evt_ready,
    input  sxfc_pkg::evt_t evt_data,
    output logic           seg_valid,
    input  logic           seg_ready,
    output sxfc_pkg::seg_t seg_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int TW = (TAG_BITS < sxfc_pkg::TAG_ID_W) ? TAG_BITS : sxfc_pkg::TAG_ID_W;
    localparam int DW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
    localparam int RW = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int DPW = sxfc_pkg::DEPTH_W;
    localparam int OW  = sxfc_pkg::OFFSET_W;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t               state_reg, state_next;
    sxfc_pkg::evt_t       item_reg;
    logic [DPW-1:0]       depth_reg, depth_next;
    logic                 cap_active_reg, cap_active_next;
    logic [15:0]          nest_reg, nest_next;
    logic [3:0]           cap_rule_reg, cap_rule_next;
    logic [OW-1:0]        cap_start_reg, cap_start_next;
    logic [31:0]          seg_cnt_reg, seg_cnt_next;
    sxfc_pkg::seg_t       seg_reg, seg_next;
    logic                 seg_valid_reg, seg_valid_next;
    logic [4:0]           rule_count_reg;
    logic [15:0]          doc_reg;

    logic                 accept;
    logic                 cfg_we;
    sxfc_pkg::rule_wr_t   rule_wr;
    logic                 rd_en;
    logic [RULES-1:0]     cand;
    logic [RULES-1:0]     done;
    logic                 hdr_bit;
    logic [DPW-1:0]       d;
    logic                 in_range;
    logic [RULES-1:0]     root;
    logic [RULES-1:0]     parent;
    logic [RULES-1:0]     hit;
    logic [RULES-1:0]     fire;
    logic [RW-1:0]        fire_idx;
    logic [RULES-1:0]     mask_mem [PATH_DEPTH];
    logic [RULES-1:0]     mask_q;
    logic                 mask_we;
    logic [RULES-1:0]     mask_wdata;
    logic                 is_start;
    logic                 is_end;
    logic                 emit;
    logic                 stall;
    logic                 seg_load;

    assign evt_ready = (state_reg == S_IDLE);
    assign accept    = evt_valid && evt_ready;
    assign seg_valid = seg_valid_reg;
    assign seg_data  = seg_reg;
    assign pready    = 1'b1;

    // ---------------- configuration ----------------
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_count_reg <= '0;
            doc_reg        <= '0;
        end
        else if (cfg_we)
        begin
            case (sxfc_pkg::reg_idx_t'(paddr[2]))
                sxfc_pkg::REG_RULE_COUNT: rule_count_reg <= pwdata[4:0];
                sxfc_pkg::REG_DOCUMENT:   doc_reg        <= pwdata[15:0];
                default:                  rule_count_reg <= rule_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sxfc_pkg::reg_idx_t'(paddr[2]))
            sxfc_pkg::REG_RULE_COUNT: prdata = {27'd0, rule_count_reg};
            sxfc_pkg::REG_DOCUMENT:   prdata = {16'd0, doc_reg};
            default:                  prdata = '0;
        endcase
    end

    // ---------------- rule tables ----------------
    always_comb
    begin
        rule_wr.step_we = accept && (evt_data.command == sxfc_pkg::CMD_WRITE_STEP);
        rule_wr.len_we  = accept && (evt_data.command == sxfc_pkg::CMD_WRITE_LEN);
        rule_wr.rule    = evt_data.rule_select;
        rule_wr.step    = evt_data.step_select;
        rule_wr.tag     = evt_data.tag_id;
        rule_wr.len     = evt_data.rule_length;
        rule_wr.hdr     = evt_data.header_flag;
    end

    // Step row d-1 is the old depth; the parent mask row d-2 is one below it.
    assign rd_en = accept && (evt_data.command == sxfc_pkg::CMD_START);

    sxfc_rule_store #(
        .RULES      (RULES),
        .PATH_DEPTH (PATH_DEPTH),
        .TAG_BITS   (TAG_BITS)
    ) u_rule_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (rule_wr),
        .rd_en     (rd_en),
        .rd_row    (depth_reg[DW-1:0]),
        .cmp_tag   (item_reg.tag_id[TW-1:0]),
        .cmp_depth (d),
        .hdr_rule  (cap_rule_reg),
        .cand      (cand),
        .done      (done),
        .hdr_bit   (hdr_bit)
    );

    // ---------------- level mask memory ----------------
    always_ff @(posedge clk)
    begin
        if (mask_we)
        begin
            mask_mem[depth_reg[DW-1:0]] <= mask_wdata;
        end
        if (rd_en)
        begin
            mask_q <= mask_mem[DW'(depth_reg - 16'd1)];
        end
    end

    // ---------------- match and capture ----------------
    always_comb
    begin
        for (int i = 0; i < RULES; i++)
        begin
            root[i] = i < int'(rule_count_reg);
        end
    end

    assign d        = depth_reg + 16'd1;
    assign in_range = int'(depth_reg) < PATH_DEPTH;
    assign is_start = (state_reg == S_EXEC) && (item_reg.command == sxfc_pkg::CMD_START);
    assign is_end   = (state_reg == S_EXEC) && (item_reg.command == sxfc_pkg::CMD_END);
    assign parent   = (d == 16'd1) ? root : mask_q;
    assign hit      = parent & cand;
    assign fire     = hit & done;

    always_comb
    begin
        fire_idx = '0;
        for (int i = RULES - 1; i >= 0; i--)
        begin
            if (fire[i])
            begin
                fire_idx = RW'(i);
            end
        end
    end

    assign mask_we    = is_start && in_range;
    assign mask_wdata = cap_active_reg ? '0 : hit;

    // Hold the closing end event while the segment register is still full.
    assign emit     = is_end && cap_active_reg && (nest_reg == 16'd1);
    assign stall    = emit && seg_valid_reg && !seg_ready;
    assign seg_load = emit && !stall;

    always_comb
    begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        cap_active_next = cap_active_reg;
        nest_next       = nest_reg;
        cap_rule_next   = cap_rule_reg;
        cap_start_next  = cap_start_reg;
        seg_cnt_next    = seg_cnt_reg;
        seg_next        = seg_reg;
        seg_valid_next  = seg_valid_reg && !seg_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!stall)
                begin
                    state_next = S_IDLE;
                end
                if (is_start)
                begin
                    depth_next = d;
                    if (cap_active_reg)
                    begin
                        nest_next = nest_reg + 16'd1;
                    end
                    else if (in_range && (fire != '0))
                    begin
                        cap_active_next = 1'b1;
                        nest_next       = 16'd1;
                        cap_rule_next   = 4'(fire_idx);
                        cap_start_next  = item_reg.source_offset;
                    end
                end
                else if (is_end && !stall)
                begin
                    depth_next = depth_reg - 16'd1;
                    if (cap_active_reg)
                    begin
                        nest_next = nest_reg - 16'd1;
                    end
                    if (seg_load)
                    begin
                        seg_next.segment_number   = seg_cnt_reg;
                        seg_next.segment_rule     = cap_rule_reg;
                        seg_next.segment_document = doc_reg;
                        seg_next.segment_start    = cap_start_reg;
                        seg_next.segment_length   = item_reg.source_offset - cap_start_reg;
                        seg_next.segment_header   = hdr_bit;
                        seg_valid_next            = 1'b1;
                        seg_cnt_next              = seg_cnt_reg + 32'd1;
                        cap_active_next           = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            depth_reg      <= '0;
            cap_active_reg <= 1'b0;
            nest_reg       <= '0;
            cap_rule_reg   <= '0;
            cap_start_reg  <= '0;
            seg_cnt_reg    <= '0;
            seg_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            depth_reg      <= depth_next;
            cap_active_reg <= cap_active_next;
            nest_reg       <= nest_next;
            cap_rule_reg   <= cap_rule_next;
            cap_start_reg  <= cap_start_next;
            seg_cnt_reg    <= seg_cnt_next;
            seg_valid_reg  <= seg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= evt_data;
        end
        seg_reg <= seg_next;
    end

`ifndef NO_ASSERTIONS
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_EXEC)
        else $error("accepted beat did not enter execute");

    a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
        seg_load |=> !cap_active_reg && seg_valid_reg)
        else $error("segment emitted but capture still open");

    a_seg_count: assert property (@(posedge clk) disable iff (!rst_n)
        seg_load |=> seg_cnt_reg == $past(seg_cnt_reg) + 32'd1)
        else $error("segment counter did not advance");

    a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |=> depth_reg == $past(depth_reg))
        else $error("depth changed outside execute");
`endif

endmodule

>>> tb/streaming_xpath_fragment_cutter_tb.sv
// Self-checking testbench of the streaming XPath fragment cutter: random event streams, segment predictor.
module streaming_xpath_fragment_cutter_tb;

    localparam int NR = sxfc_pkg::RULES_DEF;
    localparam int ND = sxfc_pkg::PATH_DEPTH_DEF;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 185;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int REPORT_CAP = 40;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           evt_valid = 1'b0;
    logic           evt_ready;
    sxfc_pkg::evt_t evt_data = '0;
    logic           seg_valid;
    logic           seg_ready = 1'b0;
    sxfc_pkg::seg_t seg_data;
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [2:0]     paddr = '0;
    logic [31:0]    pwdata = '0;
    logic [31:0]    prdata;
    logic           pready;

    streaming_xpath_fragment_cutter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt_data  (evt_data),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg_data  (seg_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Segment predictor state
    logic [15:0]    path_step [NR][ND];
    logic [4:0]     path_len [NR];
    logic           path_hdr [NR];
    logic [15:0]    live_mask [ND];
    logic [15:0]    cur_depth = '0;
    logic           in_capture = 1'b0;
    logic [15:0]    cap_nest = '0;
    logic [3:0]     cap_rule = '0;
    logic [47:0]    cap_off = '0;
    logic [31:0]    seg_count = '0;
    logic [4:0]     cfg_rules = '0;
    logic [15:0]    cfg_doc = '0;
    sxfc_pkg::seg_t segments_due [$];

    // Stimulus planning state
    sxfc_pkg::evt_t evt_plan [$];
    logic [15:0]    plan_step [NR][ND];
    logic [4:0]     plan_len [NR];
    logic [15:0]    tag_pool [4];
    logic [15:0]    gen_depth = '0;
    logic [47:0]    gen_off = '0;
    int             planned = 0;
    int             beats_queued = 0;
    int             beats_taken = 0;

    bit             evt_quiet = 1'b0;
    bit             seg_quiet = 1'b0;
    int unsigned    evt_gap = 0;
    int unsigned    seg_hold = 0;
    int unsigned    hold_next = 0;
    int             mismatches = 0;
    int             stall_count = 0;

    initial
    begin
        for (int i = 0; i < NR; i++)
        begin
            path_len[i] = '0;
            path_hdr[i] = 1'b0;
            for (int s = 0; s < ND; s++)
                path_step[i][s] = '0;
        end
        for (int s = 0; s < ND; s++)
            live_mask[s] = '0;
    end

    function automatic int unsigned idle_draw(bit quiet);
        return quiet ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic flag_mismatch(input string what);
        if (mismatches < REPORT_CAP)
            $display("mismatch: %s", what);
        mismatches++;
    endtask

    // Advance the predictor by one accepted event beat.
    function automatic void cut_fragment(sxfc_pkg::evt_t b);
        logic [15:0]    parent;
        logic [15:0]    hit;
        logic [4:0]     lim;
        int             d;
        sxfc_pkg::seg_t s;
        case (b.command)
            sxfc_pkg::CMD_START:
            begin
                cur_depth = cur_depth + 16'd1;
                d = cur_depth;
                if (d >= 1 && d <= ND)
                begin
                    if (in_capture)
                        live_mask[d-1] = '0;
                    else
                    begin
                        lim = (cfg_rules > 5'(NR)) ? 5'(NR) : cfg_rules;
                        parent = (d == 1) ? 16'((17'd1 << lim) - 17'd1) : live_mask[d-2];
                        hit = '0;
                        for (int i = 0; i < NR; i++)
                            if (parent[i] && d <= path_len[i] && path_step[i][d-1] == b.tag_id)
                                hit[i] = 1'b1;
                        live_mask[d-1] = hit;
                        // lowest rule completed at its full length wins
                        for (int i = 0; i < NR; i++)
                            if (!in_capture && hit[i] && d == path_len[i])
                            begin
                                in_capture = 1'b1;
                                cap_nest = '0;
                                cap_rule = 4'(i);
                                cap_off = b.source_offset;
                            end
                    end
                end
                if (in_capture)
                    cap_nest = cap_nest + 16'd1;
            end
            sxfc_pkg::CMD_END:
            begin
                if (in_capture)
                begin
                    cap_nest = cap_nest - 16'd1;
                    if (cap_nest == 0)
                    begin
                        s.segment_number = seg_count;
                        s.segment_rule = cap_rule;
                        s.segment_document = cfg_doc;
                        s.segment_start = cap_off;
                        s.segment_length = b.source_offset - cap_off;
                        s.segment_header = path_hdr[cap_rule];
                        segments_due.insert(segments_due.size(), s);
                        seg_count = seg_count + 32'd1;
                        in_capture = 1'b0;
                    end
                end
                cur_depth = cur_depth - 16'd1;
            end
            sxfc_pkg::CMD_WRITE_STEP:
                path_step[b.rule_select][b.step_select] = b.tag_id;
            default:
            begin
                path_len[b.rule_select] = b.rule_length;
                path_hdr[b.rule_select] = b.header_flag;
            end
        endcase
    endfunction

    task automatic compare_segment(input sxfc_pkg::seg_t got);
        sxfc_pkg::seg_t want;
        if (segments_due.size() == 0)
        begin
            flag_mismatch($sformatf("segment %0d arrived with none pending", got.segment_number));
            return;
        end
        want = segments_due.pop_front();
        if (got.segment_number !== want.segment_number)
            flag_mismatch($sformatf("segment_number got %0d want %0d",
                got.segment_number, want.segment_number));
        if (got.segment_rule !== want.segment_rule)
            flag_mismatch($sformatf("segment %0d rule got %0d want %0d",
                want.segment_number, got.segment_rule, want.segment_rule));
        if (got.segment_document !== want.segment_document)
            flag_mismatch($sformatf("segment %0d document got %h want %h",
                want.segment_number, got.segment_document, want.segment_document));
        if (got.segment_start !== want.segment_start)
            flag_mismatch($sformatf("segment %0d start got %h want %h",
                want.segment_number, got.segment_start, want.segment_start));
        if (got.segment_length !== want.segment_length)
            flag_mismatch($sformatf("segment %0d length got %h want %h",
                want.segment_number, got.segment_length, want.segment_length));
        if (got.segment_header !== want.segment_header)
            flag_mismatch($sformatf("segment %0d header got %b want %b",
                want.segment_number, got.segment_header, want.segment_header));
    endtask

    // Event driver: one beat per handshake, random gap after each beat.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid <= 1'b0;
            evt_gap <= 0;
        end
        else
        begin
            if (evt_valid && evt_ready)
            begin
                cut_fragment(evt_data);
                beats_taken++;
            end
            if (!evt_valid || evt_ready)
            begin
                if (evt_gap != 0)
                begin
                    evt_valid <= 1'b0;
                    evt_gap <= evt_gap - 1;
                end
                else if (evt_plan.size() != 0)
                begin
                    evt_data <= evt_plan.pop_front();
                    evt_valid <= 1'b1;
                    evt_gap <= idle_draw(evt_quiet);
                end
                else
                    evt_valid <= 1'b0;
            end
        end
    end

    // Segment monitor: check each beat, then stall ready for a random count.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_ready <= 1'b0;
            seg_hold <= 0;
        end
        else
        begin
            hold_next = seg_hold;
            if (seg_valid && seg_ready)
            begin
                compare_segment(seg_data);
                hold_next = idle_draw(seg_quiet);
            end
            if (hold_next != 0)
            begin
                seg_ready <= 1'b0;
                seg_hold <= hold_next - 1;
            end
            else
            begin
                seg_ready <= 1'b1;
                seg_hold <= 0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (evt_valid && evt_ready) || (seg_valid && seg_ready) || (psel && penable))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
    end

    initial
    begin
        wait (stall_count >= STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    task automatic write_reg(input sxfc_pkg::reg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == sxfc_pkg::REG_RULE_COUNT)
            cfg_rules = value[4:0];
        else
            cfg_doc = value[15:0];
    endtask

    // Hold until every beat is taken and every segment is back, then let the pipe drain.
    task automatic settle();
        while (beats_taken != beats_queued || segments_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic sxfc_pkg::evt_t rand_beat();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(sxfc_pkg::evt_t)-1:0];
    endfunction

    function automatic void put_beat(sxfc_pkg::evt_t b);
        evt_plan.insert(evt_plan.size(), b);
        beats_queued++;
        planned++;
    endfunction

    function automatic void put_elem(sxfc_pkg::cmd_t cmd, logic [15:0] tag, logic [47:0] off);
        sxfc_pkg::evt_t b;
        b = rand_beat();
        b.command = cmd;
        b.tag_id = tag;
        b.source_offset = off;
        gen_depth = (cmd == sxfc_pkg::CMD_START) ? gen_depth + 16'd1 : gen_depth - 16'd1;
        put_beat(b);
    endfunction

    function automatic void put_step(int r, int s, logic [15:0] tag);
        sxfc_pkg::evt_t b;
        b = rand_beat();
        b.command = sxfc_pkg::CMD_WRITE_STEP;
        b.rule_select = 4'(r);
        b.step_select = 4'(s);
        b.tag_id = tag;
        plan_step[r][s] = tag;
        put_beat(b);
    endfunction

    function automatic void put_len(int r, logic [4:0] len, logic hdr);
        sxfc_pkg::evt_t b;
        b = rand_beat();
        b.command = sxfc_pkg::CMD_WRITE_LEN;
        b.rule_select = 4'(r);
        b.rule_length = len;
        b.header_flag = hdr;
        plan_len[r] = len;
        put_beat(b);
    endfunction

    function automatic logic [15:0] pick_tag();
        if ($urandom_range(0, 11) == 0)
            return 16'($urandom);
        return tag_pool[$urandom_range(0, 3)];
    endfunction

    function automatic logic [47:0] advance_offset();
        if ($urandom_range(0, 39) == 0)
            gen_off = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 600));
        else
            gen_off = gen_off + 48'($urandom_range(1, 400));
        return gen_off;
    endfunction

    // One well-formed element tree, mostly walking down the path of one rule.
    function automatic void add_document();
        int          r;
        int          starts;
        int          opens;
        int          maxd;
        bit          deep;
        bit          follow;
        logic [15:0] tag;
        deep = ($urandom_range(0, 9) == 0);
        follow = ($urandom_range(0, 3) != 0);
        r = $urandom_range(0, NR - 1);
        if (deep)
        begin
            for (int i = 0; i < NR; i++)
                if (plan_len[i] == ND)
                    r = i;
            starts = ND + $urandom_range(0, 2);
            maxd = starts;
        end
        else
        begin
            starts = $urandom_range(1, 12);
            maxd = $urandom_range(1, 6);
        end
        opens = 0;
        while (starts > 0 || opens > 0)
        begin
            if (starts > 0 && opens < maxd && (deep || opens == 0 || $urandom_range(0, 2) != 0))
            begin
                if (follow && gen_depth < ND && $urandom_range(0, 7) != 0)
                    tag = plan_step[r][gen_depth];
                else
                    tag = pick_tag();
                put_elem(sxfc_pkg::CMD_START, tag, advance_offset());
                starts--;
                opens++;
            end
            else
            begin
                put_elem(sxfc_pkg::CMD_END, pick_tag(), advance_offset());
                opens--;
            end
        end
    endfunction

    function automatic void add_noise();
        logic [4:0] len;
        case ($urandom_range(0, 3))
            0: put_step($urandom_range(0, NR - 1), $urandom_range(0, ND - 1), pick_tag());
            1:
            begin
                case ($urandom_range(0, 7))
                    0: len = 5'd0;
                    1: len = 5'(ND);
                    2: len = 5'($urandom_range(ND + 1, 31));
                    default: len = 5'($urandom_range(1, 5));
                endcase
                put_len($urandom_range(0, NR - 1), len, 1'($urandom_range(0, 1)));
            end
            2:
            begin
                // broken pair: close first, may drop below the root
                put_elem(sxfc_pkg::CMD_END, pick_tag(), advance_offset());
                put_elem(sxfc_pkg::CMD_START, pick_tag(), advance_offset());
            end
            default:
            begin
                put_elem(sxfc_pkg::CMD_START, pick_tag(), advance_offset());
                put_elem(sxfc_pkg::CMD_END, pick_tag(), advance_offset());
            end
        endcase
    endfunction

    initial
    begin
        logic [4:0]  rc;
        logic [15:0] doc;
        tag_pool[0] = 16'h0000;
        tag_pool[1] = 16'hFFFF;
        tag_pool[2] = 16'($urandom);
        tag_pool[3] = 16'($urandom);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(sxfc_pkg::REG_RULE_COUNT, {27'($urandom), 5'd31});
        write_reg(sxfc_pkg::REG_DOCUMENT, {16'($urandom), 16'hFFFF});

        // Fill the whole step table so no match reads an unwritten step.
        for (int r = 0; r < NR; r++)
            for (int s = 0; s < ND; s++)
                put_step(r, s, tag_pool[$urandom_range(0, 3)]);
        put_step(0, 0, 16'hFFFF);
        put_step(0, 1, 16'h0000);
        for (int r = 0; r < NR; r++)
            put_len(r, 5'($urandom_range(1, 4)), 1'($urandom_range(0, 1)));
        put_len(0, 5'd2, 1'b1);
        put_len(12, 5'd17, 1'b0);
        put_len(13, 5'd31, 1'b1);
        put_len(14, 5'd0, 1'b1);
        put_len(15, 5'(ND), 1'b1);

        // Directed: end below the root, capture with wrapping length, nested start,
        // dead parent, extreme table writes, extreme offsets.
        put_elem(sxfc_pkg::CMD_END, 16'h0000, 48'h0);
        put_elem(sxfc_pkg::CMD_START, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
        put_elem(sxfc_pkg::CMD_START, 16'hFFFF, 48'hFFFF_FFFF_FFF0);
        put_elem(sxfc_pkg::CMD_START, 16'h0000, 48'hFFFF_FFFF_FFF8);
        put_elem(sxfc_pkg::CMD_START, 16'h7E7E, 48'h9);
        put_elem(sxfc_pkg::CMD_END, 16'hFFFF, 48'hA);
        put_elem(sxfc_pkg::CMD_END, 16'h0000, 48'hC);
        put_elem(sxfc_pkg::CMD_END, 16'hFFFF, 48'hD);
        put_elem(sxfc_pkg::CMD_START, 16'h7E7E, 48'h14);
        put_elem(sxfc_pkg::CMD_START, 16'h0000, 48'h15);
        put_elem(sxfc_pkg::CMD_END, 16'h0000, 48'h16);
        put_elem(sxfc_pkg::CMD_END, 16'h0000, 48'h17);
        put_step(15, 15, 16'hFFFF);
        put_step(3, 0, 16'h0000);
        put_len(15, 5'(ND), 1'b1);
        put_len(0, 5'd2, 1'b0);
        put_len(14, 5'd0, 1'b1);
        put_elem(sxfc_pkg::CMD_START, 16'hFFFF, 48'h0);
        put_elem(sxfc_pkg::CMD_START, 16'h0000, 48'hFFFF_FFFF_FFFF);
        put_elem(sxfc_pkg::CMD_END, 16'h0000, 48'h0);
        put_elem(sxfc_pkg::CMD_END, 16'hFFFF, 48'h1);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: rc = 5'd16;
                1: rc = 5'd0;
                2: rc = 5'd31;
                3: rc = 5'd1;
                4: rc = 5'd15;
                5: rc = 5'd17;
                default: rc = 5'($urandom_range(8, 31));
            endcase
            doc = (p == 1) ? 16'h0000 : (p == 2) ? 16'hFFFF : 16'($urandom);
            write_reg(sxfc_pkg::REG_RULE_COUNT, {27'($urandom), rc});
            write_reg(sxfc_pkg::REG_DOCUMENT, {16'($urandom), doc});
            evt_quiet = (p == 3) || (p == 6);
            seg_quiet = (p == 3) || (p == 5);
            planned = 0;
            while (planned < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 3) == 0)
                    add_noise();
                else
                    add_document();
            end
            settle();
        end

        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
sv/sxfc_pkg.sv
sv/sxfc_rule_store.sv
sv/streaming_xpath_fragment_cutter.sv
tb/streaming_xpath_fragment_cutter_tb.sv
